@@ src/bpcb_pkg.sv @@
// Shared types and constants for the button press classifier with buzzer.
`default_nettype none

package bpcb_pkg;

  // Number of button lanes, fixed by the four-bit button level field.
  localparam int unsigned NUM_BUTTONS = 4;
  // Lane that reports a long press instead of a short press.
  localparam int unsigned POWER_INDEX = 2;

  // Command codes carried by a transaction.
  typedef enum logic [1:0] {
    CMD_POLL    = 2'd0,
    CMD_PULSE   = 2'd1,
    CMD_CONSUME = 2'd2,
    CMD_OFF     = 2'd3
  } cmd_t;

  // Button event codes.
  typedef enum logic [2:0] {
    EVT_NONE       = 3'd0,
    EVT_TEST_ALARM = 3'd1,
    EVT_MUTE       = 3'd2,
    EVT_RESET      = 3'd3,
    EVT_POWER_LONG = 3'd4
  } ev_t;

  // Configuration register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_DEBOUNCE   = 2'd1,
    REG_MUTE_DUR   = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  // Short press event for each lane; the power lane has none.
  localparam ev_t SHORT_CODE [NUM_BUTTONS] = '{EVT_TEST_ALARM, EVT_MUTE, EVT_NONE, EVT_RESET};

  // Configuration register values as seen by the datapath.
  typedef struct packed {
    logic [31:0] long_press_ms;
    logic [31:0] debounce_ms;
    logic [31:0] mute_window_ms;
  } cfg_t;

  // Event posted by one button lane during a poll.
  typedef struct packed {
    logic post;
    ev_t  code;
  } btn_post_t;

endpackage

`default_nettype wire

@@ src/bpcb_cfg_regs.sv @@
// APB-style configuration registers for the button press classifier.
`default_nettype none

module bpcb_cfg_regs
  import bpcb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms  <= 32'd2000;
      cfg_r.debounce_ms    <= 32'd30;
      cfg_r.mute_window_ms <= 32'd1800000;
    end else if (wr_en) begin
      unique case (idx)
        REG_LONG_PRESS: cfg_r.long_press_ms  <= pwdata;
        REG_DEBOUNCE:   cfg_r.debounce_ms    <= pwdata;
        REG_MUTE_DUR:   cfg_r.mute_window_ms <= pwdata;
        REG_UNUSED:     ;
      endcase
    end
  end

  // Read data follows the address; the unused slot reads as zero.
  always_comb begin
    unique case (idx)
      REG_LONG_PRESS: prdata = cfg_r.long_press_ms;
      REG_DEBOUNCE:   prdata = cfg_r.debounce_ms;
      REG_MUTE_DUR:   prdata = cfg_r.mute_window_ms;
      REG_UNUSED:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/bpcb_btn_lane.sv @@
// One button lane: edge detection, press timing and event posting.
`default_nettype none

module bpcb_btn_lane
  import bpcb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        level,
  input  wire logic [31:0] now_ms,
  input  wire logic [31:0] long_press_ms,
  input  wire logic [31:0] debounce_ms,
  input  wire ev_t         short_code,
  input  wire logic        long_en,
  output btn_post_t        post
);

  logic        was_pressed_r, was_pressed_nxt;
  logic        long_sent_r, long_sent_nxt;
  logic [31:0] press_time_r, press_time_nxt;
  logic [31:0] held;

  // Hold time wraps with the millisecond counter.
  assign held = now_ms - press_time_r;

  // Next lane state and the event this sample posts, if any.
  always_comb begin
    was_pressed_nxt = level;
    long_sent_nxt   = long_sent_r;
    press_time_nxt  = press_time_r;
    post.post       = 1'b0;
    post.code       = EVT_NONE;
    if (!was_pressed_r && level) begin
      press_time_nxt = now_ms;
      long_sent_nxt  = 1'b0;
    end else if (was_pressed_r && level) begin
      if (long_en && !long_sent_r && (held >= long_press_ms)) begin
        post.post     = 1'b1;
        post.code     = EVT_POWER_LONG;
        long_sent_nxt = 1'b1;
      end
    end else if (was_pressed_r && !level) begin
      if ((held >= debounce_ms) && !long_sent_r && (short_code != EVT_NONE)) begin
        post.post = 1'b1;
        post.code = short_code;
      end
    end
  end

  // Lane state moves only on a poll transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_pressed_r <= 1'b0;
      long_sent_r   <= 1'b0;
      press_time_r  <= '0;
    end else if (en) begin
      was_pressed_r <= was_pressed_nxt;
      long_sent_r   <= long_sent_nxt;
      press_time_r  <= press_time_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/button_press_classifier_buzzer_top.sv @@
// Top level of the button press classifier with buzzer and mute window.
// Each transaction passes the input register and then the result register.
// Throughput: one transaction per cycle while out_stall is low, set by the input register
// and result register with compare and add logic between them.
// Reset (rst_n, synchronous, active low) clears all button, buzzer, mute and event state
// and loads the register defaults; no clearing pass is needed.
`default_nettype none

module button_press_classifier_buzzer_top
  import bpcb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [31:0] in_now_ms,
  input  wire logic [3:0]  in_button_levels,
  input  wire logic [31:0] in_pulse_ms,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_buzzer_on,
  output logic             out_muted,
  output logic [2:0]       out_event_res,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  // Input register
  logic                   in_valid_r;
  cmd_t                   cmd_r;
  logic [31:0]            now_r;
  logic [NUM_BUTTONS-1:0] levels_r;
  logic [31:0]            pulse_r;

  // Result register
  logic       out_valid_r;
  logic       out_buzzer_r;
  logic       out_muted_r;
  ev_t        out_event_r;

  // Block state
  ev_t         pending_r, pending_nxt;
  logic [31:0] buz_end_r, buz_end_nxt;
  logic [31:0] mute_end_r, mute_end_nxt;
  logic        buz_lvl_r, buz_lvl_nxt;

  logic      advance;
  logic      in_take;
  logic      poll_en;
  ev_t       btn_pend;
  ev_t       ev_out;
  logic      muted_nxt;
  btn_post_t posts [NUM_BUTTONS];

  bpcb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the input register advances whenever the result register is free.
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign poll_en   = advance && (cmd_r == CMD_POLL);
  assign out_valid = out_valid_r;
  assign out_buzzer_on = out_buzzer_r;
  assign out_muted     = out_muted_r;
  assign out_event_res = out_event_r;

  // Input register capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r    <= cmd_t'(in_cmd);
      now_r    <= in_now_ms;
      levels_r <= in_button_levels;
      pulse_r  <= in_pulse_ms;
    end
  end

  // One lane per button.
  for (genvar gi = 0; gi < NUM_BUTTONS; gi++) begin : g_lane
    bpcb_btn_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .en            (poll_en),
      .level         (levels_r[gi]),
      .now_ms        (now_r),
      .long_press_ms (cfg.long_press_ms),
      .debounce_ms   (cfg.debounce_ms),
      .short_code    (SHORT_CODE[gi]),
      .long_en       (1'(gi == POWER_INDEX)),
      .post          (posts[gi])
    );
  end

  // Command decode and state update; the highest posting lane wins.
  always_comb begin
    pending_nxt  = pending_r;
    buz_end_nxt  = buz_end_r;
    buz_lvl_nxt  = buz_lvl_r;
    mute_end_nxt = mute_end_r;
    ev_out       = EVT_NONE;
    btn_pend     = pending_r;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (posts[i].post) begin
        btn_pend = posts[i].code;
      end
    end
    unique case (cmd_r)
      CMD_POLL: begin
        pending_nxt = btn_pend;
        if ((buz_end_r != '0) && (now_r >= buz_end_r)) begin
          buz_end_nxt = '0;
          buz_lvl_nxt = 1'b0;
        end
        if (btn_pend == EVT_MUTE) begin
          mute_end_nxt = now_r + cfg.mute_window_ms;
          buz_end_nxt  = '0;
          buz_lvl_nxt  = 1'b0;
          pending_nxt  = EVT_NONE;
        end
      end
      CMD_PULSE: begin
        if (!(now_r < mute_end_r)) begin
          buz_end_nxt = now_r + pulse_r;
          buz_lvl_nxt = 1'b1;
        end
      end
      CMD_CONSUME: begin
        ev_out      = pending_r;
        pending_nxt = EVT_NONE;
      end
      CMD_OFF: begin
        buz_end_nxt = '0;
        buz_lvl_nxt = 1'b0;
      end
    endcase
    muted_nxt = (now_r < mute_end_nxt);
  end

  // Block state moves when a transaction passes to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= EVT_NONE;
      buz_end_r  <= '0;
      mute_end_r <= '0;
      buz_lvl_r  <= 1'b0;
    end else if (advance) begin
      pending_r  <= pending_nxt;
      buz_end_r  <= buz_end_nxt;
      mute_end_r <= mute_end_nxt;
      buz_lvl_r  <= buz_lvl_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_buzzer_r <= buz_lvl_nxt;
      out_muted_r  <= muted_nxt;
      out_event_r  <= ev_out;
    end
  end

  // A posted mute event is always consumed in the same poll.
  a_no_mute_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != EVT_MUTE)
    else $error("mute event left pending");

  // A consume transaction leaves nothing pending.
  a_consume_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (cmd_r == CMD_CONSUME) |=> pending_r == EVT_NONE)
    else $error("pending event survived consume");

  // Buzzer off drives the buzzer low and clears the pulse end time.
  a_off_stops: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (cmd_r == CMD_OFF) |=> !buz_lvl_r && (buz_end_r == '0))
    else $error("buzzer still active after off command");

  // A result is never overwritten while it is stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !advance)
    else $error("stalled result overwritten");

endmodule

`default_nettype wire
